// ----- src/stsh_pkg.sv -----
// Shared types, codes and defaults for the stripe target share block.
package stsh_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_STRIPES_DEF = 256;
	localparam int BLOCK_BYTES_DEF = 512;

	// Field widths
	localparam int SLOT_W   = 8;
	localparam int TID_W    = 16;
	localparam int FBYTES_W = 48;
	localparam int BLOCKS_W = 39;
	localparam int STRIPE_W = 32;
	localparam int TOTAL_W  = 9;
	localparam int STATUS_W = 2;

	// Shared arithmetic unit sizing
	localparam int ALU_W     = 40;
	localparam int DIV_STEPS = BLOCKS_W;
	localparam int MUL_STEPS = STRIPE_W;
	localparam int STEP_W    = 6;

	// Command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ABSENT     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_STRIPE = 2'd2;

	typedef struct packed {
		logic                cmd;
		logic [SLOT_W-1:0]   entry_slot;
		logic [TID_W-1:0]    target_id;
		logic [FBYTES_W-1:0] file_bytes;
		logic [BLOCKS_W-1:0] block_count;
		logic [STRIPE_W-1:0] stripe_bytes;
		logic [TOTAL_W-1:0]  stripe_total;
	} req_t;

	typedef struct packed {
		logic                has_data;
		logic [BLOCKS_W-1:0] target_blocks;
		logic [STATUS_W-1:0] status;
	} rsp_t;

endpackage

// ----- src/stsh_table.sv -----
// Layout table: one write port, one registered read port.
module stsh_table
	import stsh_pkg::*;
#(
	parameter int DEPTH = MAX_STRIPES_DEF,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [TID_W-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [TID_W-1:0] rd_data
);

	logic [TID_W-1:0] mem [DEPTH];

	// Write on load, read every cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- src/stripe_target_share_core.sv -----
// Top level: per-target share of a round-robin striped file.
//
// Usage: drive req and raise start; a transaction is taken at a rising edge
// with start high and busy low. Every transaction yields one result on rsp,
// marked by done for exactly one cycle; the receiver cannot stall it.
// Load (cmd 0) writes one layout entry and answers zeros;
// busy stays low, so loads may follow each other every cycle.
// Query (cmd 1) scans the layout table one entry per cycle through its
// registered read port, stopping at the lowest matching position or at the
// end of the n stripes, then runs one shared 40-bit add/subtract unit:
// three restoring divisions of 39 steps, one 32-step shift-add multiply
// and the steps PRES, CHKK, SUB, PREP and FIN; busy stays high until the
// result is registered, but stays low for a query with zero stripe total.
// Reset clears the sequencer and the strobe; the layout table is not
// cleared, and entries must be loaded before a query scans them.
module stripe_target_share_core
	import stsh_pkg::*;
#(
	parameter int MAX_STRIPES = MAX_STRIPES_DEF,
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int AW   = (MAX_STRIPES > 1) ? $clog2(MAX_STRIPES) : 1;
	localparam int CW   = $clog2(MAX_STRIPES + 1);
	localparam int PW   = AW + STRIPE_W;
	localparam int CMPW = (PW > FBYTES_W) ? PW : FBYTES_W;

	// Sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCAN = 4'd1;
	localparam logic [3:0] S_PRES = 4'd2;
	localparam logic [3:0] S_DIVK = 4'd3;
	localparam logic [3:0] S_CHKK = 4'd4;
	localparam logic [3:0] S_DIVB = 4'd5;
	localparam logic [3:0] S_SUB  = 4'd6;
	localparam logic [3:0] S_DIVN = 4'd7;
	localparam logic [3:0] S_PREP = 4'd8;
	localparam logic [3:0] S_MUL  = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	logic [3:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic [CW-1:0]     idx_q;
	logic              cmp_vld_q;

	logic [TID_W-1:0]    tid_q;
	logic [FBYTES_W-1:0] fb_q;
	logic [BLOCKS_W-1:0] blk_q;
	logic [STRIPE_W-1:0] sb_q;
	logic [CW-1:0]       n_q;
	logic [CW-1:0]       cmp_idx_q;
	logic [AW-1:0]       pos_q;
	logic                has_q;
	logic [BLOCKS_W-1:0] quo_q;
	logic [STRIPE_W-1:0] rem_q;
	logic [STRIPE_W-1:0] div_q;
	logic [STRIPE_W-1:0] k_q;
	logic [STRIPE_W-1:0] rem_b_q;
	logic [BLOCKS_W-1:0] opd_q;
	logic [STRIPE_W-1:0] extra_q;
	rsp_t                rsp_q;

	logic                accept;
	logic [CW-1:0]       n_in;
	logic                tbl_wr_en;
	logic [TID_W-1:0]    tbl_rd_data;
	logic                hit;
	logic                last_cmp;
	logic [PW-1:0]       prod;
	logic                present;
	logic [STRIPE_W:0]   rem_sh;
	logic [ALU_W-1:0]    op_a;
	logic [ALU_W-1:0]    op_b;
	logic                alu_sub;
	logic [ALU_W-1:0]    alu_sum;
	logic                alu_neg;
	logic                fin;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign accept = start && !busy;

	// Clamp the stripe total to the table depth
	assign n_in = (32'(req.stripe_total) > 32'(MAX_STRIPES)) ? CW'(MAX_STRIPES)
		: CW'(req.stripe_total);

	assign tbl_wr_en = accept && (req.cmd == CMD_LOAD)
		&& (32'(req.entry_slot) < 32'(MAX_STRIPES));

	stsh_table #(
		.DEPTH(MAX_STRIPES),
		.AW   (AW)
	) u_table (
		.clk    (clk),
		.wr_en  (tbl_wr_en),
		.wr_addr(AW'(req.entry_slot)),
		.wr_data(req.target_id),
		.rd_addr(idx_q[AW-1:0]),
		.rd_data(tbl_rd_data)
	);

	// Scan compare on the registered table output
	assign hit      = cmp_vld_q && (tbl_rd_data == tid_q);
	assign last_cmp = (CW'(cmp_idx_q + 1'b1) == n_q);

	// Presence: position p holds data when p * stripe_bytes < file_bytes
	assign prod    = PW'(pos_q) * PW'(sb_q);
	assign present = (sb_q != '0) && (CMPW'(prod) < CMPW'(fb_q));

	// Shared add/subtract unit operand select
	assign rem_sh = {rem_q, quo_q[BLOCKS_W-1]};

	always_comb begin
		op_a    = '0;
		op_b    = '0;
		alu_sub = 1'b0;
		case (state_q) inside
			S_DIVK, S_DIVB, S_DIVN: begin
				op_a    = ALU_W'(rem_sh);
				op_b    = ALU_W'(div_q);
				alu_sub = 1'b1;
			end
			S_SUB: begin
				op_a    = ALU_W'(quo_q);
				op_b    = ALU_W'(pos_q);
				alu_sub = 1'b1;
			end
			S_MUL: begin
				op_a = ALU_W'({quo_q[BLOCKS_W-2:0], 1'b0});
				op_b = k_q[STRIPE_W-1] ? ALU_W'(opd_q) : '0;
			end
			S_FIN: begin
				op_a = ALU_W'(quo_q);
				op_b = ALU_W'(extra_q);
			end
			default: begin
				op_a    = '0;
				op_b    = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	assign alu_sum = op_a + (alu_sub ? ~op_b : op_b) + ALU_W'(alu_sub);
	assign alu_neg = alu_sum[ALU_W-1];

	// Flag the cycle that ends a transaction
	always_comb begin
		fin = 1'b0;
		unique case (state_q)
			S_IDLE:  fin = accept && (req.cmd == CMD_LOAD || n_in == '0);
			S_SCAN:  fin = !hit && cmp_vld_q && last_cmp;
			S_PRES:  fin = (sb_q == '0);
			S_CHKK:  fin = (rem_q != '0) || (blk_q == '0);
			S_SUB:   fin = alu_neg;
			S_FIN:   fin = 1'b1;
			default: fin = 1'b0;
		endcase
	end

	// Sequencer: state, step count, scan index and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= '0;
			done_q    <= 1'b0;
			idx_q     <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			done_q <= fin;
			unique case (state_q)
				S_IDLE: begin
					if (accept && req.cmd == CMD_QUERY && n_in != '0) begin
						state_q   <= S_SCAN;
						idx_q     <= '0;
						cmp_vld_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (idx_q < n_q) begin
						idx_q     <= idx_q + 1'b1;
						cmp_vld_q <= 1'b1;
					end else begin
						cmp_vld_q <= 1'b0;
					end
					if (hit) begin
						state_q <= S_PRES;
					end else if (cmp_vld_q && last_cmp) begin
						state_q <= S_IDLE;
					end
				end
				S_PRES: begin
					if (sb_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIVK;
						step_q  <= STEP_W'(DIV_STEPS - 1);
					end
				end
				S_DIVK, S_DIVB, S_DIVN: begin
					if (step_q != '0) begin
						step_q <= step_q - 1'b1;
					end else if (state_q == S_DIVK) begin
						state_q <= S_CHKK;
					end else if (state_q == S_DIVB) begin
						state_q <= S_SUB;
					end else begin
						state_q <= S_PREP;
					end
				end
				S_CHKK: begin
					if (rem_q != '0 || blk_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIVB;
						step_q  <= STEP_W'(DIV_STEPS - 1);
					end
				end
				S_SUB: begin
					if (alu_neg) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIVN;
						step_q  <= STEP_W'(DIV_STEPS - 1);
					end
				end
				S_PREP: begin
					state_q <= S_MUL;
					step_q  <= STEP_W'(MUL_STEPS - 1);
				end
				S_MUL: begin
					if (step_q != '0) begin
						step_q <= step_q - 1'b1;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath: operands, shared unit results and the result register
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					tid_q <= req.target_id;
					fb_q  <= req.file_bytes;
					blk_q <= req.block_count;
					sb_q  <= req.stripe_bytes;
					n_q   <= n_in;
					rsp_q <= '{has_data: 1'b0, target_blocks: '0,
						status: (req.cmd == CMD_QUERY && n_in == '0) ? ST_ABSENT : ST_OK};
				end
			end
			S_SCAN: begin
				cmp_idx_q <= idx_q;
				if (hit) begin
					pos_q <= cmp_idx_q[AW-1:0];
				end else if (cmp_vld_q && last_cmp) begin
					rsp_q <= '{has_data: 1'b0, target_blocks: '0, status: ST_ABSENT};
				end
			end
			S_PRES: begin
				has_q <= present;
				rsp_q <= '{has_data: 1'b0, target_blocks: '0, status: ST_OK};
				quo_q <= BLOCKS_W'(sb_q);
				rem_q <= '0;
				div_q <= STRIPE_W'(BLOCK_BYTES);
			end
			S_DIVK, S_DIVB, S_DIVN: begin
				quo_q <= {quo_q[BLOCKS_W-2:0], !alu_neg};
				rem_q <= alu_neg ? rem_sh[STRIPE_W-1:0] : alu_sum[STRIPE_W-1:0];
			end
			S_CHKK: begin
				if (rem_q != '0) begin
					rsp_q <= '{has_data: has_q, target_blocks: '0, status: ST_BAD_STRIPE};
				end else if (blk_q == '0) begin
					rsp_q <= '{has_data: has_q, target_blocks: '0, status: ST_OK};
				end else begin
					k_q   <= quo_q[STRIPE_W-1:0];
					div_q <= quo_q[STRIPE_W-1:0];
					quo_q <= blk_q;
					rem_q <= '0;
				end
			end
			S_SUB: begin
				rem_b_q <= rem_q;
				if (alu_neg) begin
					rsp_q <= '{has_data: has_q, target_blocks: '0, status: ST_OK};
				end else begin
					quo_q <= alu_sum[BLOCKS_W-1:0];
					rem_q <= '0;
					div_q <= STRIPE_W'(n_q);
				end
			end
			S_PREP: begin
				// A partial round adds one stripe, else the tail blocks count
				opd_q   <= quo_q;
				extra_q <= (rem_q != '0) ? k_q : rem_b_q;
				quo_q   <= '0;
			end
			S_MUL: begin
				quo_q <= alu_sum[BLOCKS_W-1:0];
				k_q   <= {k_q[STRIPE_W-2:0], 1'b0};
			end
			S_FIN: begin
				rsp_q <= '{has_data: has_q, target_blocks: alu_sum[BLOCKS_W-1:0],
					status: ST_OK};
			end
			default: begin
				rsp_q <= rsp_q;
			end
		endcase
	end

endmodule

// ----- tb/stripe_target_share_core_tb.sv -----
// Testbench for the stripe target share core: directed rows, then random layouts and queries.
`timescale 1ns / 1ps

module stripe_target_share_core_tb;
	import stsh_pkg::*;

	localparam int N_ITEMS   = 1850;
	localparam int STALL_MAX = 5000;
	localparam int SHOW_MAX  = 10;
	localparam int N_ROWS    = 19;
	localparam logic [63:0] BLK = 64'(BLOCK_BYTES_DEF);
	localparam logic [63:0] FB_MAX = 64'hFFFF_FFFF_FFFF;
	localparam logic [63:0] BC_MAX = 64'h7F_FFFF_FFFF;

	// One directed row: the transaction and, where pinned, its expected result
	typedef struct {
		req_t r;
		bit   pinned;
		rsp_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	// Pinned expectation, launched together with req
	bit   pin_on = 1'b0;
	rsp_t pin_rsp = '0;

	logic [TID_W-1:0] layout_ids [MAX_STRIPES_DEF];
	logic [TID_W-1:0] plan_ids [MAX_STRIPES_DEF];
	rsp_t pending_shares [$];
	int fail_cnt = 0;
	int stall_cnt = 0;
	int sent = 0;
	bit idle_on = 1'b1;
	row_t rows [N_ROWS];

	stripe_target_share_core #(
		.MAX_STRIPES(MAX_STRIPES_DEF),
		.BLOCK_BYTES(BLOCK_BYTES_DEF)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	// Compute the share of one transaction; loads update the layout copy
	function automatic rsp_t share_of(input req_t r);
		rsp_t o;
		int unsigned n;
		int unsigned pos;
		int unsigned i;
		bit hit;
		logic [63:0] fb, bc, sb, bytes, full, last, d, match, extra;
		o = '0;
		if (r.cmd == CMD_LOAD) begin
			layout_ids[r.entry_slot] = r.target_id;
			return o;
		end
		n = (r.stripe_total > MAX_STRIPES_DEF) ? MAX_STRIPES_DEF : r.stripe_total;
		hit = 1'b0;
		pos = 0;
		for (i = 0; i < n && !hit; i++) begin
			if (layout_ids[i] == r.target_id) begin
				hit = 1'b1;
				pos = i;
			end
		end
		if (!hit) begin
			o.status = ST_ABSENT;
			return o;
		end
		fb = 64'(r.file_bytes);
		bc = 64'(r.block_count);
		sb = 64'(r.stripe_bytes);
		// present when the position lies within the stripes the file touches
		if (fb != 0 && sb != 0 && 64'(pos) < (fb + sb - 1) / sb)
			o.has_data = 1'b1;
		if (sb != 0 && sb % BLK != 0) begin
			o.status = ST_BAD_STRIPE;
		end else if (sb != 0 && bc != 0) begin
			bytes = bc * BLK;
			full = bytes / sb;
			last = bytes % sb;
			// a position past the full stripes holds nothing
			if (full >= 64'(pos)) begin
				d = full - 64'(pos);
				match = d / 64'(n);
				extra = '0;
				if (d % 64'(n) != 0)
					match = match + 1;
				else
					extra = (last + BLK - 1) / BLK;
				o.target_blocks = BLOCKS_W'(match * (sb / BLK) + extra);
			end
		end
		return o;
	endfunction

	function automatic logic [63:0] rnd_w(input int w);
		logic [63:0] v;
		v = {$urandom, $urandom};
		if (w <= 0)
			return '0;
		if (w < 64)
			v = v & ((64'd1 << w) - 64'd1);
		return v;
	endfunction

	function automatic int clip(input int v, input int hi);
		return (v < 0) ? 0 : (v > hi) ? hi : v;
	endfunction

	function automatic req_t ld(input int slot, input logic [TID_W-1:0] tid);
		req_t r;
		r.cmd = CMD_LOAD;
		r.entry_slot = SLOT_W'(slot);
		r.target_id = tid;
		r.file_bytes = FBYTES_W'(rnd_w(FBYTES_W));
		r.block_count = BLOCKS_W'(rnd_w(BLOCKS_W));
		r.stripe_bytes = $urandom;
		r.stripe_total = TOTAL_W'($urandom);
		return r;
	endfunction

	function automatic req_t qy(input logic [TID_W-1:0] tid, input logic [63:0] fb,
			input logic [63:0] bc, input logic [STRIPE_W-1:0] sb, input int tot);
		req_t r;
		r.cmd = CMD_QUERY;
		r.entry_slot = SLOT_W'($urandom);
		r.target_id = tid;
		r.file_bytes = FBYTES_W'(fb);
		r.block_count = BLOCKS_W'(bc);
		r.stripe_bytes = sb;
		r.stripe_total = TOTAL_W'(tot);
		return r;
	endfunction

	function automatic rsp_t rs(input logic h, input logic [BLOCKS_W-1:0] b,
			input logic [STATUS_W-1:0] s);
		rsp_t o;
		o.has_data = h;
		o.target_blocks = b;
		o.status = s;
		return o;
	endfunction

	function automatic logic [TID_W-1:0] pick_id();
		int k;
		k = $urandom_range(99);
		// small ids repeat often, which exercises the lowest-index match
		if (k < 40)
			return TID_W'($urandom_range(5));
		if (k < 50)
			return '1;
		return TID_W'($urandom);
	endfunction

	// Launch one transaction at a falling edge and hold it until taken
	task automatic send(input req_t r, input bit pinned, input rsp_t want);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 14) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req <= r;
		pin_on <= pinned;
		pin_rsp <= want;
		do
			@(posedge clk);
		while (busy);
		sent++;
	endtask

	task automatic put_load(input int slot, input logic [TID_W-1:0] tid);
		plan_ids[slot] = tid;
		send(ld(slot, tid), 1'b0, '0);
	endtask

	task automatic put_query(input int lay_n, input int tot);
		int lim;
		int k;
		int w;
		logic [STRIPE_W-1:0] sb;
		logic [63:0] fb;
		logic [63:0] bc;
		logic [TID_W-1:0] tid;
		lim = (tot > MAX_STRIPES_DEF) ? MAX_STRIPES_DEF : tot;
		if (lim == 0)
			lim = lay_n;
		// stripe size: mostly block multiples, some odd sizes and extremes
		k = $urandom_range(99);
		if (k < 8)
			sb = '0;
		else if (k < 76)
			sb = 32'(rnd_w($urandom_range(22)) + 1) << 9;
		else if (k < 90)
			sb = 32'(rnd_w($urandom_range(1, 32)));
		else if (k < 95)
			sb = 32'hFFFF_FE00;
		else
			sb = '1;
		w = $clog2(sb);
		// file size near the stripe span, or anywhere
		k = $urandom_range(99);
		if (k < 5)
			fb = '0;
		else if (k < 9)
			fb = FB_MAX;
		else if (k < 55)
			fb = rnd_w(clip(w + int'($urandom_range(10)) - 2, FBYTES_W));
		else
			fb = rnd_w($urandom_range(FBYTES_W));
		// block count near a few rounds of the layout, or anywhere
		k = $urandom_range(99);
		if (k < 5)
			bc = '0;
		else if (k < 9)
			bc = BC_MAX;
		else if (k < 65)
			bc = rnd_w(clip(w - 9 + $clog2(lim + 1) + int'($urandom_range(6)) - 2,
				BLOCKS_W));
		else
			bc = rnd_w($urandom_range(BLOCKS_W));
		if ($urandom_range(99) < 72)
			tid = plan_ids[$urandom_range(lim - 1)];
		else
			tid = TID_W'($urandom);
		send(qy(tid, fb, bc, sb, tot), 1'b0, '0);
	endtask

	task automatic cmp(input string field, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			fail_cnt++;
			if (fail_cnt <= SHOW_MAX)
				$display("%0t %s mismatch: expected %0h, got %0h", $time, field, want, got);
		end
	endtask

	// Predict at each accepted transaction, check each result strobe
	always @(posedge clk) begin : mon
		rsp_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (done) begin
				moved = 1'b1;
				if (pending_shares.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= SHOW_MAX)
						$display("%0t result with nothing pending: %p", $time, rsp);
				end else begin
					want = pending_shares.pop_front();
					cmp("has_data", 64'(want.has_data), 64'(rsp.has_data));
					cmp("target_blocks", 64'(want.target_blocks), 64'(rsp.target_blocks));
					cmp("status", 64'(want.status), 64'(rsp.status));
				end
			end
			if (start && !busy) begin
				moved = 1'b1;
				want = share_of(req);
				if (pin_on)
					want = pin_rsp;
				pending_shares.push_back(want);
			end
		end
		stall_cnt = moved ? 0 : stall_cnt + 1;
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		while (stall_cnt < STALL_MAX)
			@(posedge clk);
		$display("simulation failed");
		$finish;
	end

	initial begin : run
		int i;
		int k;
		int lay_n;
		// loads answer zeros
		rows[0]  = '{ld(0, 16'h0000), 1'b1, rs(1'b0, '0, ST_OK)};
		rows[1]  = '{ld(1, 16'hFFFF), 1'b1, rs(1'b0, '0, ST_OK)};
		rows[2]  = '{ld(2, 16'h1234), 1'b1, rs(1'b0, '0, ST_OK)};
		rows[3]  = '{ld(3, 16'hFFFF), 1'b1, rs(1'b0, '0, ST_OK)};
		rows[4]  = '{ld(255, 16'hABCD), 1'b1, rs(1'b0, '0, ST_OK)};
		// zero stripe total, absent target, zero stripe size, empty file
		rows[5]  = '{qy(16'h0000, 1000, 10, 512, 0), 1'b1, rs(1'b0, '0, ST_ABSENT)};
		rows[6]  = '{qy(16'h5555, 4096, 8, 512, 4), 1'b1, rs(1'b0, '0, ST_ABSENT)};
		rows[7]  = '{qy(16'h0000, FB_MAX, BC_MAX, 0, 4), 1'b1, rs(1'b0, '0, ST_OK)};
		rows[8]  = '{qy(16'h5555, 4096, 8, 0, 4), 1'b1, rs(1'b0, '0, ST_ABSENT)};
		rows[9]  = '{qy(16'h0000, 0, 0, 4096, 4), 1'b1, rs(1'b0, '0, ST_OK)};
		// stripe size not a block multiple
		rows[10] = '{qy(16'hFFFF, 5000, 100, 1000, 4), 1'b1, rs(1'b1, '0, ST_BAD_STRIPE)};
		rows[11] = '{qy(16'h0000, FB_MAX, BC_MAX, 32'hFFFF_FFFF, 4), 1'b1,
			rs(1'b1, '0, ST_BAD_STRIPE)};
		// shares: duplicate id, past the full stripes, partial last stripe, extremes
		rows[12] = '{qy(16'h1234, 3000, 10, 1024, 4), 1'b0, '0};
		rows[13] = '{qy(16'hFFFF, 1024, 7, 512, 4), 1'b0, '0};
		rows[14] = '{qy(16'h1234, 4096, 8, 4096, 4), 1'b0, '0};
		rows[15] = '{qy(16'hFFFF, 40000, 11, 4096, 4), 1'b0, '0};
		rows[16] = '{qy(16'h0000, FB_MAX, BC_MAX, 32'hFFFF_FE00, 4), 1'b0, '0};
		rows[17] = '{qy(16'hFFFF, 4096, 8, 512, 1), 1'b1, rs(1'b0, '0, ST_ABSENT)};
		rows[18] = '{qy(16'h0000, 1, 5, 512, 2), 1'b0, '0};

		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// walk the directed rows
		for (i = 0; i < N_ROWS; i++) begin
			if (rows[i].r.cmd == CMD_LOAD)
				plan_ids[rows[i].r.entry_slot] = rows[i].r.target_id;
			send(rows[i].r, rows[i].pinned, rows[i].want);
		end

		// fill the whole layout so every later scan reads written entries
		for (i = 0; i < MAX_STRIPES_DEF; i++)
			put_load(i, pick_id());
		lay_n = MAX_STRIPES_DEF;
		// stripe totals at and past the table depth; those past it saturate
		put_query(lay_n, 511);
		put_query(lay_n, 257);
		put_query(lay_n, 256);

		// random layouts, each followed by a burst of queries and a few stray loads
		while (sent < N_ITEMS) begin
			idle_on = !(sent >= 700 && sent < 1100);
			if ($urandom_range(99) < 30) begin
				k = $urandom_range(99);
				if (k < 70)
					lay_n = $urandom_range(1, 8);
				else if (k < 95)
					lay_n = $urandom_range(9, 64);
				else
					lay_n = $urandom_range(65, MAX_STRIPES_DEF);
				for (i = 0; i < lay_n; i++)
					put_load(i, pick_id());
			end
			repeat ($urandom_range(2, 10)) begin
				k = $urandom_range(99);
				if (k < 8)
					put_load($urandom_range(MAX_STRIPES_DEF - 1), pick_id());
				else if (k < 80)
					put_query(lay_n, lay_n);
				else if (k < 88)
					put_query(lay_n, $urandom_range(1, lay_n));
				else if (k < 95)
					put_query(lay_n, $urandom_range(511));
				else
					put_query(lay_n, 0);
			end
		end

		// drain the pending results, then watch for strays
		@(negedge clk);
		start <= 1'b0;
		while (pending_shares.size() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
		if (fail_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- files.f -----
src/stsh_pkg.sv
src/stsh_table.sv
src/stripe_target_share_core.sv
tb/stripe_target_share_core_tb.sv
